[hw/rtl/fbik_pkg.sv]
// ----------------------------------------------------------------------------
// fbik_pkg
// Shared constants, types and step functions for the five-bar inverse
// kinematics pipeline: square-root steps, CORDIC steps, status codes.
// ----------------------------------------------------------------------------
package fbik_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int TABLE_LEN     = 24;
	localparam int CD_STEPS      = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

	localparam int SQW       = 62;
	localparam int SQ1_BITS  = 50;
	localparam int SQ1_STEPS = SQ1_BITS / 2;
	localparam int SQ2_BITS  = 62;
	localparam int SQ2_STEPS = SQ2_BITS / 2;

	localparam int CW       = 36;
	localparam int ZW       = 27;
	localparam int NORM_MSB = 30;

	localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(90 * 65536);

	// round(atan(2^-i) deg * 65536)
	localparam logic [21:0] ATAN_TAB [TABLE_LEN] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
		22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
		22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
		22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
	};

	localparam logic [1:0] REG_BASE  = 2'd0;
	localparam logic [1:0] REG_UPPER = 2'd1;
	localparam logic [1:0] REG_LOWER = 2'd2;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BOUND   = 3'd1,
		ST_ANG1    = 3'd2,
		ST_ANG2    = 3'd3,
		ST_UNREACH = 3'd4
	} status_t;

	typedef struct packed {
		logic [SQW-1:0] v;
		logic [SQW-1:0] r;
	} sq_t;

	typedef struct packed {
		logic                  zr;
		logic signed [CW-1:0]  x;
		logic signed [CW-1:0]  y;
		logic signed [ZW-1:0]  z;
	} cd_t;

	// one bit-pair step of floor square root
	function automatic sq_t sq_step(sq_t a, logic [SQW-1:0] b);
		sq_t            o;
		logic [SQW-1:0] t;
		t = a.r + b;
		if (a.v >= t) begin
			o.v = a.v - t;
			o.r = (a.r >> 1) + b;
		end else begin
			o.v = a.v;
			o.r = a.r >> 1;
		end
		return o;
	endfunction

	// quadrant fold ahead of vectoring
	function automatic cd_t cd_pre(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
		cd_t o;
		o.zr = (x == '0) && (y == '0);
		o.x  = x;
		o.y  = y;
		o.z  = '0;
		if (x < 0) begin
			if (y >= 0) begin
				o.x = y;
				o.y = -x;
				o.z = Z_QUARTER;
			end else begin
				o.x = -y;
				o.y = x;
				o.z = -Z_QUARTER;
			end
		end
		return o;
	endfunction

	function automatic cd_t cd_step(cd_t a, int i);
		cd_t                  o;
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		logic signed [ZW-1:0] at;
		xs   = a.x >>> i;
		ys   = a.y >>> i;
		at   = $signed({{(ZW-22){1'b0}}, ATAN_TAB[i]});
		o.zr = a.zr;
		if (a.y > 0) begin
			o.x = a.x + ys;
			o.y = a.y - xs;
			o.z = a.z + at;
		end else begin
			o.x = a.x - ys;
			o.y = a.y + xs;
			o.z = a.z - at;
		end
		return o;
	endfunction

	// degrees with 16 fraction bits to whole degrees, toward zero
	function automatic logic signed [10:0] to_deg(logic signed [ZW:0] v);
		logic [ZW:0]      m;
		logic signed [11:0] d;
		m = (v < 0) ? $unsigned(-v) : $unsigned(v);
		d = $signed({1'b0, m[ZW-1:16]});
		if (v < 0)
			d = -d;
		return d[10:0];
	endfunction

	function automatic logic [5:0] msb_pos(logic [41:0] d);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 42; i++)
			if (d[i])
				p = 6'(i);
		return p;
	endfunction

endpackage

[hw/rtl/five_bar_inverse_kinematics.sv]
// ----------------------------------------------------------------------------
// five_bar_inverse_kinematics
// Target point to joint angles for a two-motor five-bar linkage.
// ----------------------------------------------------------------------------
// Usage:
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the base
//   half spacing, upper and lower link lengths; cfg_ready is always high.
//   Write only while no item is in flight. Unused indexes are ignored.
//   Input channel (in_valid/in_stall) carries target_x, target_y; a transfer
//   happens when in_valid is high and in_stall low.
//   Output channel (out_valid/out_stall) carries status and both angles.
//   Throughput: one item per cycle while out_stall holds no waiting result.
//   From transfer to out_valid an item passes the capture, offset, square
//   and sum registers, the two bit-per-stage square roots (25 and 31 stages),
//   the normalize steps, the CORDIC stages and the combine and output registers.
//   While out_stall holds a waiting result the whole pipeline freezes; a
//   one-entry skid register still takes one more input, then in_stall rises.
//   Reset clears all valid bits and loads the default link geometry.
// ----------------------------------------------------------------------------
module five_bar_inverse_kinematics import fbik_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic signed [7:0] target_x,
	input  logic signed [7:0] target_y,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        status,
	output logic signed [9:0] joint_one_angle,
	output logic signed [9:0] joint_two_angle
);

	typedef struct packed {
		logic               xpos;
		logic               xneg;
		logic signed [15:0] tx;
		logic signed [15:0] ty;
		logic signed [17:0] dxa;
		logic signed [17:0] dxb;
	} fr_t;

	typedef struct packed {
		fr_t                f;
		logic               rneg;
		logic signed [43:0] numa;
		logic signed [43:0] numb;
		sq_t                rq;
		sq_t                la;
		sq_t                lb;
	} p1_t;

	typedef struct packed {
		logic signed [43:0] num;
		logic [41:0]        den;
		logic               bad;
		logic [5:0]         p;
	} nl_t;

	typedef struct packed {
		logic               bnd;
		logic signed [15:0] ty;
		logic signed [17:0] dxa;
		logic signed [17:0] dxb;
		nl_t                a;
		nl_t                b;
	} nrm_t;

	typedef struct packed {
		logic signed [31:0] num;
		logic [30:0]        dm;
		logic [31:0]        dp;
	} cl_t;

	typedef struct packed {
		logic               bnd;
		logic               unr;
		logic signed [15:0] ty;
		logic signed [17:0] dxa;
		logic signed [17:0] dxb;
		cl_t                a;
		cl_t                b;
	} clp_t;

	typedef struct packed {
		logic               bnd;
		logic               unr;
		logic signed [15:0] ty;
		logic signed [17:0] dxa;
		logic signed [17:0] dxb;
		logic signed [31:0] numa;
		logic signed [31:0] numb;
		sq_t                ha;
		sq_t                hb;
	} p2_t;

	typedef struct packed {
		logic bnd;
		logic unr;
		cd_t  aa;
		cd_t  ab;
		cd_t  da;
		cd_t  db;
	} p3_t;

	function automatic nl_t lane_chk(nl_t l);
		nl_t         o;
		logic [43:0] mag;
		o     = l;
		mag   = (l.num < 0) ? $unsigned(-l.num) : $unsigned(l.num);
		o.bad = (l.den == '0) || (mag > {2'b00, l.den});
		o.p   = msb_pos(l.den);
		return o;
	endfunction

	function automatic nl_t lane_shift(nl_t l);
		nl_t o;
		o = l;
		if (l.p > 6'(NORM_MSB)) begin
			o.num = l.num >>> (l.p - 6'(NORM_MSB));
			o.den = l.den >> (l.p - 6'(NORM_MSB));
		end else begin
			o.num = l.num <<< (6'(NORM_MSB) - l.p);
			o.den = l.den << (6'(NORM_MSB) - l.p);
		end
		return o;
	endfunction

	function automatic cl_t lane_clamp(nl_t l);
		cl_t                o;
		logic signed [32:0] n;
		logic signed [32:0] d;
		logic signed [32:0] a;
		d = $signed({2'b00, l.den[30:0]});
		n = $signed(l.num[32:0]);
		if (n > d)
			n = d;
		else if (n < -d)
			n = -d;
		a     = (n < 0) ? -n : n;
		o.num = n[31:0];
		o.dm  = l.den[30:0] - a[30:0];
		o.dp  = {1'b0, l.den[30:0]} + {1'b0, a[30:0]};
		return o;
	endfunction

	// configuration
	logic [15:0] base_q, upper_q, lower_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= 16'd256;
			upper_q <= 16'd975;
			lower_q <= 16'd1231;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BASE:  base_q  <= cfg_data;
				REG_UPPER: upper_q <= cfg_data;
				REG_LOWER: lower_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance and input skid
	logic              adv, in_acc;
	logic              skid_v_q;
	logic signed [7:0] skid_x_q, skid_y_q;
	logic              ov_q;

	assign adv      = !(ov_q && out_stall);
	assign in_stall = skid_v_q;
	assign in_acc   = in_valid && !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			skid_v_q <= 1'b0;
		else if (adv)
			skid_v_q <= 1'b0;
		else if (in_acc)
			skid_v_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (!adv && in_acc) begin
			skid_x_q <= target_x;
			skid_y_q <= target_y;
		end
	end

	// s1: capture
	logic              v_s1;
	logic signed [7:0] x_s1, y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= skid_v_q || in_acc;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= skid_v_q ? skid_x_q : target_x;
			y_s1 <= skid_v_q ? skid_y_q : target_y;
		end
	end

	// s2: offsets
	logic        v_s2;
	fr_t         fr_s2;
	logic [16:0] rmax_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fr_s2.xpos <= !x_s1[7] && (x_s1 != '0);
			fr_s2.xneg <= x_s1[7];
			fr_s2.tx   <= {x_s1, 8'h00};
			fr_s2.ty   <= {y_s1, 8'h00};
			fr_s2.dxa  <= 18'($signed({x_s1, 8'h00})) + $signed({2'b00, base_q});
			fr_s2.dxb  <= 18'($signed({x_s1, 8'h00})) - $signed({2'b00, base_q});
			rmax_s2    <= 17'(upper_q) + 17'(lower_q);
		end
	end

	// s3: squares
	logic               v_s3;
	fr_t                fr_s3;
	logic [33:0]        rm2_s3, dxa2_s3, dxb2_s3;
	logic [30:0]        ty2_s3;
	logic [31:0]        r1sq_s3, r2sq_s3;
	logic signed [31:0] ty2_c;
	logic signed [35:0] dxa2_c, dxb2_c;

	always_comb begin
		ty2_c  = fr_s2.ty * fr_s2.ty;
		dxa2_c = fr_s2.dxa * fr_s2.dxa;
		dxb2_c = fr_s2.dxb * fr_s2.dxb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (adv)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fr_s3   <= fr_s2;
			rm2_s3  <= 34'(rmax_s2) * 34'(rmax_s2);
			ty2_s3  <= ty2_c[30:0];
			dxa2_s3 <= dxa2_c[33:0];
			dxb2_s3 <= dxb2_c[33:0];
			r1sq_s3 <= 32'(upper_q) * 32'(upper_q);
			r2sq_s3 <= 32'(lower_q) * 32'(lower_q);
		end
	end

	// s4: sums
	logic               v_s4;
	fr_t                fr_s4;
	logic signed [35:0] rad_s4;
	logic [34:0]        lsqa_s4, lsqb_s4;
	logic signed [32:0] kk_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (adv)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fr_s4   <= fr_s3;
			rad_s4  <= $signed({2'b00, rm2_s3}) - $signed({5'b00000, ty2_s3});
			lsqa_s4 <= 35'(dxa2_s3) + 35'(ty2_s3);
			lsqb_s4 <= 35'(dxb2_s3) + 35'(ty2_s3);
			kk_s4   <= $signed({1'b0, r1sq_s3}) - $signed({1'b0, r2sq_s3});
		end
	end

	// square roots: reach and both motor distances
	p1_t  p1_s  [0:SQ1_STEPS];
	logic p1v_s [0:SQ1_STEPS];
	p1_t  p1_c;

	always_comb begin
		p1_c.f    = fr_s4;
		p1_c.rneg = rad_s4[35];
		p1_c.numa = (44'($signed({1'b0, lsqa_s4})) + 44'(kk_s4)) <<< 8;
		p1_c.numb = (44'($signed({1'b0, lsqb_s4})) + 44'(kk_s4)) <<< 8;
		p1_c.rq.v = rad_s4[35] ? '0 : SQW'(rad_s4[34:0]);
		p1_c.rq.r = '0;
		p1_c.la.v = SQW'({lsqa_s4, 16'h0000});
		p1_c.la.r = '0;
		p1_c.lb.v = SQW'({lsqb_s4, 16'h0000});
		p1_c.lb.r = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			p1v_s[0] <= 1'b0;
		else if (adv)
			p1v_s[0] <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv)
			p1_s[0] <= p1_c;
	end

	for (genvar j = 1; j <= SQ1_STEPS; j++) begin : g_sq1
		localparam logic [SQW-1:0] B = SQW'(1) << (SQ1_BITS - 2 * j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				p1v_s[j] <= 1'b0;
			else if (adv)
				p1v_s[j] <= p1v_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				p1_s[j].f    <= p1_s[j-1].f;
				p1_s[j].rneg <= p1_s[j-1].rneg;
				p1_s[j].numa <= p1_s[j-1].numa;
				p1_s[j].numb <= p1_s[j-1].numb;
				p1_s[j].rq   <= sq_step(p1_s[j-1].rq, B);
				p1_s[j].la   <= sq_step(p1_s[j-1].la, B);
				p1_s[j].lb   <= sq_step(p1_s[j-1].lb, B);
			end
		end
	end

	// n1: reach bound, denominators
	logic               nv_s1, nv_s2, nv_s3, nv_s4;
	nrm_t               n_s1, n_s2, n_s3;
	clp_t               n_s4;
	nrm_t               n1_c;
	logic signed [18:0] qms_c, tx_c;
	logic [40:0]        dpa_c, dpb_c;

	always_comb begin
		qms_c  = $signed({2'b00, p1_s[SQ1_STEPS].rq.r[16:0]}) - $signed({3'b000, base_q});
		tx_c   = 19'(p1_s[SQ1_STEPS].f.tx);
		dpa_c  = upper_q * p1_s[SQ1_STEPS].la.r[24:0];
		dpb_c  = upper_q * p1_s[SQ1_STEPS].lb.r[24:0];
		n1_c.bnd   = p1_s[SQ1_STEPS].rneg ||
		             (p1_s[SQ1_STEPS].f.xpos && (tx_c > qms_c)) ||
		             (p1_s[SQ1_STEPS].f.xneg && (tx_c < -qms_c));
		n1_c.ty    = p1_s[SQ1_STEPS].f.ty;
		n1_c.dxa   = p1_s[SQ1_STEPS].f.dxa;
		n1_c.dxb   = p1_s[SQ1_STEPS].f.dxb;
		n1_c.a.num = p1_s[SQ1_STEPS].numa;
		n1_c.a.den = {dpa_c, 1'b0};
		n1_c.a.bad = 1'b0;
		n1_c.a.p   = '0;
		n1_c.b.num = p1_s[SQ1_STEPS].numb;
		n1_c.b.den = {dpb_c, 1'b0};
		n1_c.b.bad = 1'b0;
		n1_c.b.p   = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nv_s1 <= 1'b0;
			nv_s2 <= 1'b0;
			nv_s3 <= 1'b0;
			nv_s4 <= 1'b0;
		end else if (adv) begin
			nv_s1 <= p1v_s[SQ1_STEPS];
			nv_s2 <= nv_s1;
			nv_s3 <= nv_s2;
			nv_s4 <= nv_s3;
		end
	end

	// n2: reach check, leading one; n3: normalize; n4: clamp
	always_ff @(posedge clk) begin
		if (adv) begin
			n_s1       <= n1_c;
			n_s2.bnd   <= n_s1.bnd;
			n_s2.ty    <= n_s1.ty;
			n_s2.dxa   <= n_s1.dxa;
			n_s2.dxb   <= n_s1.dxb;
			n_s2.a     <= lane_chk(n_s1.a);
			n_s2.b     <= lane_chk(n_s1.b);
			n_s3.bnd   <= n_s2.bnd;
			n_s3.ty    <= n_s2.ty;
			n_s3.dxa   <= n_s2.dxa;
			n_s3.dxb   <= n_s2.dxb;
			n_s3.a     <= lane_shift(n_s2.a);
			n_s3.b     <= lane_shift(n_s2.b);
			n_s4.bnd   <= n_s3.bnd;
			n_s4.unr   <= n_s3.a.bad || n_s3.b.bad;
			n_s4.ty    <= n_s3.ty;
			n_s4.dxa   <= n_s3.dxa;
			n_s4.dxb   <= n_s3.dxb;
			n_s4.a     <= lane_clamp(n_s3.a);
			n_s4.b     <= lane_clamp(n_s3.b);
		end
	end

	// second square root: sine side of the law-of-cosines angle
	p2_t         p2_s  [0:SQ2_STEPS];
	logic        p2v_s [0:SQ2_STEPS];
	p2_t         p2_c;
	logic [62:0] pra_c, prb_c;

	always_comb begin
		pra_c     = n_s4.a.dm * n_s4.a.dp;
		prb_c     = n_s4.b.dm * n_s4.b.dp;
		p2_c.bnd  = n_s4.bnd;
		p2_c.unr  = n_s4.unr;
		p2_c.ty   = n_s4.ty;
		p2_c.dxa  = n_s4.dxa;
		p2_c.dxb  = n_s4.dxb;
		p2_c.numa = n_s4.a.num;
		p2_c.numb = n_s4.b.num;
		p2_c.ha.v = pra_c[SQW-1:0];
		p2_c.ha.r = '0;
		p2_c.hb.v = prb_c[SQW-1:0];
		p2_c.hb.r = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			p2v_s[0] <= 1'b0;
		else if (adv)
			p2v_s[0] <= nv_s4;
	end

	always_ff @(posedge clk) begin
		if (adv)
			p2_s[0] <= p2_c;
	end

	for (genvar j = 1; j <= SQ2_STEPS; j++) begin : g_sq2
		localparam logic [SQW-1:0] B = SQW'(1) << (SQ2_BITS - 2 * j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				p2v_s[j] <= 1'b0;
			else if (adv)
				p2v_s[j] <= p2v_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				p2_s[j].bnd  <= p2_s[j-1].bnd;
				p2_s[j].unr  <= p2_s[j-1].unr;
				p2_s[j].ty   <= p2_s[j-1].ty;
				p2_s[j].dxa  <= p2_s[j-1].dxa;
				p2_s[j].dxb  <= p2_s[j-1].dxb;
				p2_s[j].numa <= p2_s[j-1].numa;
				p2_s[j].numb <= p2_s[j-1].numb;
				p2_s[j].ha   <= sq_step(p2_s[j-1].ha, B);
				p2_s[j].hb   <= sq_step(p2_s[j-1].hb, B);
			end
		end
	end

	// CORDIC: two direction angles, two law-of-cosines angles
	p3_t  p3_s  [0:CD_STEPS];
	logic p3v_s [0:CD_STEPS];
	p3_t  p3_c;

	always_comb begin
		p3_c.bnd = p2_s[SQ2_STEPS].bnd;
		p3_c.unr = p2_s[SQ2_STEPS].unr;
		p3_c.aa  = cd_pre(CW'(p2_s[SQ2_STEPS].numa),
		                  $signed({5'b00000, p2_s[SQ2_STEPS].ha.r[30:0]}));
		p3_c.ab  = cd_pre(CW'(p2_s[SQ2_STEPS].numb),
		                  $signed({5'b00000, p2_s[SQ2_STEPS].hb.r[30:0]}));
		p3_c.da  = cd_pre(CW'($signed({p2_s[SQ2_STEPS].dxa, 12'h000})),
		                  CW'($signed({p2_s[SQ2_STEPS].ty, 12'h000})));
		p3_c.db  = cd_pre(CW'($signed({p2_s[SQ2_STEPS].dxb, 12'h000})),
		                  CW'($signed({p2_s[SQ2_STEPS].ty, 12'h000})));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			p3v_s[0] <= 1'b0;
		else if (adv)
			p3v_s[0] <= p2v_s[SQ2_STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv)
			p3_s[0] <= p3_c;
	end

	for (genvar j = 1; j <= CD_STEPS; j++) begin : g_cd
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				p3v_s[j] <= 1'b0;
			else if (adv)
				p3v_s[j] <= p3v_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				p3_s[j].bnd <= p3_s[j-1].bnd;
				p3_s[j].unr <= p3_s[j-1].unr;
				p3_s[j].aa  <= cd_step(p3_s[j-1].aa, j - 1);
				p3_s[j].ab  <= cd_step(p3_s[j-1].ab, j - 1);
				p3_s[j].da  <= cd_step(p3_s[j-1].da, j - 1);
				p3_s[j].db  <= cd_step(p3_s[j-1].db, j - 1);
			end
		end
	end

	// f1: combine angles
	logic                 fv_s1, bnd_s1, unr_s1;
	logic signed [10:0]   th1_s1, th2_s1;
	logic signed [ZW-1:0] zaa_c, zab_c, zda_c, zdb_c;

	always_comb begin
		zaa_c = p3_s[CD_STEPS].aa.zr ? '0 : p3_s[CD_STEPS].aa.z;
		zab_c = p3_s[CD_STEPS].ab.zr ? '0 : p3_s[CD_STEPS].ab.z;
		zda_c = p3_s[CD_STEPS].da.zr ? '0 : p3_s[CD_STEPS].da.z;
		zdb_c = p3_s[CD_STEPS].db.zr ? '0 : p3_s[CD_STEPS].db.z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fv_s1 <= 1'b0;
		else if (adv)
			fv_s1 <= p3v_s[CD_STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bnd_s1 <= p3_s[CD_STEPS].bnd;
			unr_s1 <= p3_s[CD_STEPS].unr;
			th1_s1 <= to_deg((ZW+1)'(zda_c) - (ZW+1)'(zaa_c));
			th2_s1 <= to_deg((ZW+1)'(zdb_c) + (ZW+1)'(zab_c));
		end
	end

	// output register
	status_t           status_q;
	logic signed [9:0] ang1_q, ang2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (adv)
			ov_q <= fv_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			priority if (bnd_s1) begin
				status_q <= ST_BOUND;
				ang1_q   <= '0;
				ang2_q   <= '0;
			end else if (unr_s1) begin
				status_q <= ST_UNREACH;
				ang1_q   <= '0;
				ang2_q   <= '0;
			end else if ((th1_s1 > 11'sd0) || (th1_s1 < -11'sd180)) begin
				status_q <= ST_ANG1;
				ang1_q   <= th1_s1[9:0];
				ang2_q   <= th2_s1[9:0];
			end else if ((th2_s1 > 11'sd0) || (th2_s1 < -11'sd180)) begin
				status_q <= ST_ANG2;
				ang1_q   <= th1_s1[9:0];
				ang2_q   <= th2_s1[9:0];
			end else begin
				status_q <= ST_OK;
				ang1_q   <= th1_s1[9:0];
				ang2_q   <= th2_s1[9:0];
			end
		end
	end

	assign out_valid       = ov_q;
	assign status          = status_q;
	assign joint_one_angle = ang1_q;
	assign joint_two_angle = ang2_q;

`ifndef SYNTHESIS
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && !adv) |=> (skid_v_q && $stable(skid_x_q) && $stable(skid_y_q)))
		else $error("skid entry lost while frozen");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= ST_UNREACH))
		else $error("status code out of range");

	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_OK)) |->
		((joint_one_angle <= 10'sd0) && (joint_one_angle >= -10'sd180) &&
		 (joint_two_angle <= 10'sd0) && (joint_two_angle >= -10'sd180)))
		else $error("ok status with angle out of range");

	a_zero_angles: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ((status == ST_BOUND) || (status == ST_UNREACH))) |->
		((joint_one_angle == '0) && (joint_two_angle == '0)))
		else $error("angles not cleared on fault");
`endif

endmodule

[tb/tb_five_bar_inverse_kinematics.sv]
// ----------------------------------------------------------------------------
// tb_five_bar_inverse_kinematics
// Self-checking bench for the five-bar inverse kinematics pipeline. A directed
// table of target points runs first, then random points over several link
// geometries, each compared field by field to a fixed table entry or to an
// in-bench fixed-point model of reach check, square roots and CORDIC angles.
// ----------------------------------------------------------------------------
module tb_five_bar_inverse_kinematics;
	import fbik_pkg::*;

	typedef struct {
		status_t           st;
		logic signed [9:0] a1;
		logic signed [9:0] a2;
	} pose_t;

	typedef struct {
		logic signed [7:0] x;
		logic signed [7:0] y;
		bit                fixed;
		pose_t             res;
	} point_row_t;

	localparam longint ONE_DEG = 65536;
	localparam longint ARCTAN [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [15:0]       cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic signed [7:0] target_x;
	logic signed [7:0] target_y;
	logic              out_valid;
	logic              out_stall;
	logic [2:0]        status;
	logic signed [9:0] joint_one_angle;
	logic signed [9:0] joint_two_angle;

	longint spacing, upper_len, lower_len;
	pose_t  pending_poses[$];
	int     mismatches, checked, sent, stall_mode, stall_cnt;
	int     status_seen[5];

	five_bar_inverse_kinematics dut (.*);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#60_000_000;
		$display("timeout with %0d results outstanding", pending_poses.size());
		$display("*** FAILED ***");
		$finish;
	end

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint z, t, nx, ny;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = 90 * ONE_DEG;
			end else begin
				t = x; x = -y; y = t; z = -90 * ONE_DEG;
			end
		end
		for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += ARCTAN[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= ARCTAN[i];
			end
			x = nx;
			y = ny;
		end
		return z;
	endfunction

	function automatic bit motor_angle(longint dx, longint ty, bit elbow_plus,
			output longint deg);
		longint lsq, l, num, den, a, h, ac, dir;
		lsq = dx * dx + ty * ty;
		l = longint'(floor_sqrt(longint'(lsq) << 16));
		num = (lsq + upper_len * upper_len - lower_len * lower_len) * 256;
		den = 2 * upper_len * l;
		deg = 0;
		if (den <= 0)
			return 0;
		if ((num < 0 ? -num : num) > den)
			return 0;
		while (den >= (64'sd1 << 31)) begin
			num = num >>> 1;
			den >>= 1;
		end
		while (den < (64'sd1 << 30)) begin
			num *= 2;
			den *= 2;
		end
		if (num > den) num = den;
		if (num < -den) num = -den;
		a = num < 0 ? -num : num;
		h = longint'(floor_sqrt((den - a) * (den + a)));
		ac = vector_angle(h, num);
		dir = vector_angle(ty * 4096, dx * 4096);
		deg = elbow_plus ? (dir + ac) / ONE_DEG : (dir - ac) / ONE_DEG;
		return 1;
	endfunction

	function automatic pose_t solve_pose(logic signed [7:0] x, logic signed [7:0] y);
		pose_t  p;
		longint tx, ty, rmax, rad, q, th1, th2;
		tx = longint'(x) * 256;
		ty = longint'(y) * 256;
		rmax = upper_len + lower_len;
		rad = rmax * rmax - ty * ty;
		th1 = 0;
		th2 = 0;
		p.st = ST_OK;
		if (rad < 0) begin
			p.st = ST_BOUND;
		end else begin
			q = longint'(floor_sqrt(rad));
			if ((x > 0 && tx > q - spacing) || (x < 0 && tx < spacing - q))
				p.st = ST_BOUND;
		end
		if (p.st == ST_OK) begin
			if (!motor_angle(tx + spacing, ty, 1'b0, th1) ||
					!motor_angle(tx - spacing, ty, 1'b1, th2)) begin
				p.st = ST_UNREACH;
				th1 = 0;
				th2 = 0;
			end else if (th1 > 0 || th1 < -180) begin
				p.st = ST_ANG1;
			end else if (th2 > 0 || th2 < -180) begin
				p.st = ST_ANG2;
			end
		end
		p.a1 = th1[9:0];
		p.a2 = th2[9:0];
		return p;
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_BASE:  spacing   = val;
			REG_UPPER: upper_len = val;
			REG_LOWER: lower_len = val;
			default: ;
		endcase
	endtask

	task automatic drain;
		while (pending_poses.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// leaves in_valid high; caller lowers it when a gap follows
	task automatic send_point(logic signed [7:0] x, logic signed [7:0] y,
			bit fixed = 0, pose_t res = '{ST_OK, 0, 0});
		pose_t p;
		in_valid <= 1'b1;
		target_x <= x;
		target_y <= y;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		p = solve_pose(x, y);
		if (fixed && (p.st != res.st || p.a1 != res.a1 || p.a2 != res.a2))
			$display("note: table row (%0d,%0d) disagrees with model", x, y);
		pending_poses.push_back(fixed ? res : p);
		sent++;
	endtask

	task automatic random_phase(int count, int reach, bit hold_off);
		int               burst, gap, rng;
		logic signed [7:0] x, y;
		rng = reach > 127 ? 127 : reach;
		burst = $urandom_range(1, 20);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 4) == 0) begin
				x = 8'($urandom);
				y = 8'($urandom);
			end else begin
				x = 8'(int'($urandom_range(0, 2 * rng)) - rng);
				y = 8'(int'($urandom_range(0, 2 * rng)) - rng);
			end
			send_point(x, y);
			if (hold_off && n == count / 2) begin
				in_valid <= 1'b0;
				while (pending_poses.size() != 0)
					@(posedge clk);
			end else if (--burst == 0) begin
				burst = $urandom_range(1, 20);
				gap = $urandom_range(0, 6);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		in_valid <= 1'b0;
	endtask

	// receiver: stall pattern is redrawn at random from four modes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_mode <= 0;
			stall_cnt  <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt % 64 == 63)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				3: out_stall <= stall_cnt[3];
				default: out_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		pose_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_poses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d angles %0d %0d",
						status, joint_one_angle, joint_two_angle);
			end else begin
				want = pending_poses.pop_front();
				checked++;
				if (want.st <= ST_UNREACH)
					status_seen[want.st]++;
				if (status !== want.st || joint_one_angle !== want.a1 ||
						joint_two_angle !== want.a2) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch #%0d: expected %0d/%0d/%0d got %0d/%0d/%0d",
							checked, want.st, want.a1, want.a2,
							status, joint_one_angle, joint_two_angle);
				end
			end
		end
	end

	point_row_t points[] = '{
		'{8'sd127, 8'sd127, 1, '{ST_BOUND, 0, 0}},
		'{-8'sd128, -8'sd128, 1, '{ST_BOUND, 0, 0}},
		'{8'sd0, 8'sd127, 1, '{ST_BOUND, 0, 0}},
		'{8'sd0, -8'sd128, 1, '{ST_BOUND, 0, 0}},
		'{8'sd127, 8'sd0, 1, '{ST_BOUND, 0, 0}},
		'{-8'sd128, 8'sd0, 1, '{ST_BOUND, 0, 0}},
		'{8'sd0, 8'sd0, 0, '{ST_OK, 0, 0}},
		'{8'sd0, -8'sd5, 0, '{ST_OK, 0, 0}},
		'{8'sd0, -8'sd6, 0, '{ST_OK, 0, 0}},
		'{8'sd1, -8'sd7, 0, '{ST_OK, 0, 0}},
		'{-8'sd1, -8'sd5, 0, '{ST_OK, 0, 0}},
		'{8'sd2, -8'sd3, 0, '{ST_OK, 0, 0}},
		'{-8'sd2, -8'sd3, 0, '{ST_OK, 0, 0}},
		'{8'sd0, 8'sd5, 0, '{ST_OK, 0, 0}},
		'{8'sd0, -8'sd1, 0, '{ST_OK, 0, 0}},
		'{8'sd0, -8'sd8, 0, '{ST_OK, 0, 0}},
		'{8'sd8, -8'sd1, 0, '{ST_OK, 0, 0}},
		'{-8'sd8, -8'sd1, 0, '{ST_OK, 0, 0}},
		'{8'sd1, 8'sd0, 0, '{ST_OK, 0, 0}},
		'{-8'sd1, 8'sd0, 0, '{ST_OK, 0, 0}}
	};

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		target_x  = '0;
		target_y  = '0;
		spacing   = 256;
		upper_len = 975;
		lower_len = 1231;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (points[i])
			send_point(points[i].x, points[i].y, points[i].fixed, points[i].res);
		in_valid <= 1'b0;
		drain();

		// no upper link: origin is unreachable
		write_reg(REG_UPPER, 16'd0);
		send_point(8'sd0, 8'sd0, 1, '{ST_UNREACH, 0, 0});
		in_valid <= 1'b0;
		drain();
		write_reg(2'd3, 16'hFFFF);
		write_reg(REG_UPPER, 16'd975);

		random_phase(150, 10, 1);
		drain();
		write_reg(REG_BASE, 16'd1280);
		write_reg(REG_UPPER, 16'd5120);
		write_reg(REG_LOWER, 16'd7680);
		random_phase(150, 52, 0);
		drain();
		write_reg(REG_BASE, 16'd0);
		random_phase(110, 52, 0);
		drain();
		write_reg(REG_BASE, 16'hFFFF);
		random_phase(110, 127, 0);
		drain();
		write_reg(REG_BASE, 16'd512);
		write_reg(REG_UPPER, 16'hFFFF);
		random_phase(110, 127, 0);
		drain();
		write_reg(REG_LOWER, 16'hFFFF);
		random_phase(110, 127, 0);
		drain();
		write_reg(REG_UPPER, 16'd2560);
		write_reg(REG_LOWER, 16'd0);
		random_phase(110, 12, 0);
		drain();
		write_reg(REG_UPPER, 16'd0);
		random_phase(60, 5, 0);
		drain();
		write_reg(REG_BASE, 16'd256);
		write_reg(REG_UPPER, 16'd975);
		write_reg(REG_LOWER, 16'd1231);
		random_phase(200, 10, 1);
		drain();

		$display("%0d points sent, %0d results checked over nine link geometries",
			sent, checked);
		$display("status mix ok/bound/angle1/angle2/unreachable: %0d/%0d/%0d/%0d/%0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3],
			status_seen[4]);
		if (mismatches == 0 && pending_poses.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/fbik_pkg.sv
hw/rtl/five_bar_inverse_kinematics.sv
tb/tb_five_bar_inverse_kinematics.sv
